/* rtl/svmc_pkg.sv */
// Package: shared types and constants for the stereo volume and mute controller.
`timescale 1ns / 1ps

package svmc_pkg;

    localparam int CMD_W   = 2;
    localparam int STAGE_W = 3;
    localparam int VOL_W   = 8;

    localparam logic [VOL_W-1:0] VOL_MAX = {VOL_W{1'b1}};
    localparam logic [VOL_W-1:0] VOL_MIN = '0;

    typedef enum logic [CMD_W-1:0] {
        CMD_TOGGLE = 2'd0,
        CMD_UP     = 2'd1,
        CMD_DOWN   = 2'd2,
        CMD_IGNORE = 2'd3
    } t_cmd;

    // Write request from the update logic to the stage register file
    typedef struct packed {
        logic             flip;
        logic             vol_we;
        logic [VOL_W-1:0] right;
        logic [VOL_W-1:0] left;
    } t_upd;

endpackage

/* rtl/svmc_regs.sv */
// Per-stage state: unmuted flag and right and left volume, one read and one write port.
`timescale 1ns / 1ps

module svmc_regs #(
    parameter int NUM_STAGES = 6,
    parameter int IDX_W      = 3
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [IDX_W-1:0]          i_idx,
    input  svmc_pkg::t_upd            i_upd,
    output logic                      o_unmuted,
    output logic [svmc_pkg::VOL_W-1:0] o_right,
    output logic [svmc_pkg::VOL_W-1:0] o_left
);
    import svmc_pkg::*;

    logic             r_flag  [NUM_STAGES];
    logic [VOL_W-1:0] r_right [NUM_STAGES];
    logic [VOL_W-1:0] r_left  [NUM_STAGES];

    // Read the addressed stage
    assign o_unmuted = r_flag[i_idx];
    assign o_right   = r_right[i_idx];
    assign o_left    = r_left[i_idx];

    // Clear on reset, apply flag flip and volume write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_STAGES; i++) begin
                r_flag[i]  <= 1'b0;
                r_right[i] <= VOL_MIN;
                r_left[i]  <= VOL_MIN;
            end
        end else begin
            if (i_upd.flip) begin
                r_flag[i_idx] <= ~r_flag[i_idx];
            end
            if (i_upd.vol_we) begin
                r_right[i_idx] <= i_upd.right;
                r_left[i_idx]  <= i_upd.left;
            end
        end
    end

endmodule

/* rtl/svmc_calc.sv */
// Update logic: saturating volume step, mute toggle and message decision.
`timescale 1ns / 1ps

module svmc_calc (
    input  logic                        i_vld,
    input  svmc_pkg::t_cmd              i_cmd,
    input  logic [svmc_pkg::VOL_W-1:0]  i_right_step,
    input  logic [svmc_pkg::VOL_W-1:0]  i_left_step,
    input  logic                        i_cur_unmuted,
    input  logic [svmc_pkg::VOL_W-1:0]  i_cur_right,
    input  logic [svmc_pkg::VOL_W-1:0]  i_cur_left,
    output svmc_pkg::t_upd              o_upd,
    output logic                        o_emit,
    output logic                        o_unmuted
);
    import svmc_pkg::*;

    logic [VOL_W:0]   w_sum_r;
    logic [VOL_W:0]   w_sum_l;
    logic [VOL_W-1:0] w_new_r;
    logic [VOL_W-1:0] w_new_l;
    logic             w_changed;

    assign w_sum_r = {1'b0, i_cur_right} + {1'b0, i_right_step};
    assign w_sum_l = {1'b0, i_cur_left} + {1'b0, i_left_step};

    // Saturate up at full scale, down at zero
    always_comb begin
        case (i_cmd)
            CMD_UP: begin
                w_new_r = w_sum_r[VOL_W] ? VOL_MAX : w_sum_r[VOL_W-1:0];
                w_new_l = w_sum_l[VOL_W] ? VOL_MAX : w_sum_l[VOL_W-1:0];
            end
            CMD_DOWN: begin
                w_new_r = (i_cur_right > i_right_step) ? i_cur_right - i_right_step : VOL_MIN;
                w_new_l = (i_cur_left > i_left_step) ? i_cur_left - i_left_step : VOL_MIN;
            end
            default: begin
                w_new_r = i_cur_right;
                w_new_l = i_cur_left;
            end
        endcase
    end

    assign w_changed = (w_new_r != i_cur_right) || (w_new_l != i_cur_left);

    // Decide write and message per command
    always_comb begin
        o_upd.flip   = 1'b0;
        o_upd.vol_we = 1'b0;
        o_upd.right  = w_new_r;
        o_upd.left   = w_new_l;
        o_emit       = 1'b0;
        o_unmuted    = i_cur_unmuted;
        case (i_cmd)
            CMD_TOGGLE: begin
                o_upd.flip = i_vld;
                o_emit     = i_vld;
                o_unmuted  = ~i_cur_unmuted;
            end
            CMD_UP, CMD_DOWN: begin
                o_upd.vol_we = i_vld && w_changed;
                o_emit       = i_vld && w_changed;
            end
            default: begin
                o_emit = 1'b0;
            end
        endcase
    end

endmodule

/* rtl/stereo_volume_mute_controller.sv */
// Top level: stereo volume and mute controller with input and result registers.
//
//  channel  | handshake          | ports
//  ---------+--------------------+-----------------------------------------------
//  command  | i_start / o_busy   | i_command, i_stage_index, i_right_step, i_left_step
//  result   | o_valid (strobe)   | o_stage_out, o_unmuted_out, o_right_level, o_left_level
//
// A command is taken into the input register; in the next cycle the stage state is read,
// updated and the result register loaded, which drives the o_valid strobe.
// One command per cycle: the state read-modify-write of each command sets the rate, and a
// following command sees the state that the previous one left.
// Reset clears all stages to muted and zero volume; o_busy is high only while in reset.
// The receiver cannot stall; a command that changes nothing gives no strobe.
`timescale 1ns / 1ps

module stereo_volume_mute_controller #(
    parameter int NUM_STAGES = 6
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    output logic                        o_busy,
    input  logic [svmc_pkg::CMD_W-1:0]  i_command,
    input  logic [svmc_pkg::STAGE_W-1:0] i_stage_index,
    input  logic [svmc_pkg::VOL_W-1:0]  i_right_step,
    input  logic [svmc_pkg::VOL_W-1:0]  i_left_step,
    output logic                        o_valid,
    output logic [svmc_pkg::STAGE_W-1:0] o_stage_out,
    output logic                        o_unmuted_out,
    output logic [svmc_pkg::VOL_W-1:0]  o_right_level,
    output logic [svmc_pkg::VOL_W-1:0]  o_left_level
);
    import svmc_pkg::*;

    localparam int IDX_W = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1;
    localparam int CMP_W = 5;

    logic               r_busy;
    logic               r_in_vld;
    t_cmd               r_cmd;
    logic [STAGE_W-1:0] r_stage;
    logic [VOL_W-1:0]   r_rstep;
    logic [VOL_W-1:0]   r_lstep;

    logic               r_out_vld;
    logic [STAGE_W-1:0] r_stage_out;
    logic               r_unmuted_out;
    logic [VOL_W-1:0]   r_right_lvl;
    logic [VOL_W-1:0]   r_left_lvl;

    logic               w_accept;
    logic               w_in_range;
    logic [IDX_W-1:0]   w_idx;
    logic               w_cur_unmuted;
    logic [VOL_W-1:0]   w_cur_right;
    logic [VOL_W-1:0]   w_cur_left;
    t_upd               w_upd;
    logic               w_emit;
    logic               w_unmuted;

    assign w_accept   = i_start && !r_busy;
    assign w_in_range = (r_stage != '0) && (CMP_W'(r_stage) <= CMP_W'(NUM_STAGES));
    assign w_idx      = IDX_W'(r_stage - STAGE_W'(1));

    // Capture a command on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b1;
            r_in_vld <= 1'b0;
        end else begin
            r_busy   <= 1'b0;
            r_in_vld <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd   <= t_cmd'(i_command);
            r_stage <= i_stage_index;
            r_rstep <= i_right_step;
            r_lstep <= i_left_step;
        end
    end

    svmc_regs #(
        .NUM_STAGES (NUM_STAGES),
        .IDX_W      (IDX_W)
    ) u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_idx     (w_idx),
        .i_upd     (w_upd),
        .o_unmuted (w_cur_unmuted),
        .o_right   (w_cur_right),
        .o_left    (w_cur_left)
    );

    svmc_calc u_calc (
        .i_vld         (r_in_vld && w_in_range),
        .i_cmd         (r_cmd),
        .i_right_step  (r_rstep),
        .i_left_step   (r_lstep),
        .i_cur_unmuted (w_cur_unmuted),
        .i_cur_right   (w_cur_right),
        .i_cur_left    (w_cur_left),
        .o_upd         (w_upd),
        .o_emit        (w_emit),
        .o_unmuted     (w_unmuted)
    );

    // Load the result register; strobe for one cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_stage_out   <= r_stage;
            r_unmuted_out <= w_unmuted;
            r_right_lvl   <= w_upd.right;
            r_left_lvl    <= w_upd.left;
        end
    end

    assign o_busy        = r_busy;
    assign o_valid       = r_out_vld;
    assign o_stage_out   = r_stage_out;
    assign o_unmuted_out = r_unmuted_out;
    assign o_right_level = r_right_lvl;
    assign o_left_level  = r_left_lvl;

    // A message always names a stage that exists
    a_stage_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_stage_out != '0) && (CMP_W'(o_stage_out) <= CMP_W'(NUM_STAGES)))
        else $error("result names a stage out of range");

    // A message follows a command captured in the input register
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_in_vld))
        else $error("result without a captured command");

    // A volume write or mute flip always comes with a message
    a_write_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_upd.vol_we || w_upd.flip) |=> o_valid)
        else $error("state changed without a message");

endmodule
